// File: design/spdy_rse_pkg.sv
package spdy_rse_pkg;

  // frame length bound and byte counter width
  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  // outcome codes
  localparam logic [2:0] OUTCOME_FOUND       = 3'd0;
  localparam logic [2:0] OUTCOME_NOT_CONTROL = 3'd1;
  localparam logic [2:0] OUTCOME_BAD_VERSION = 3'd2;
  localparam logic [2:0] OUTCOME_NOT_REPLY   = 3'd3;
  localparam logic [2:0] OUTCOME_MISSING     = 3'd4;

  // accepted protocol values
  localparam logic [7:0] VERSION_2       = 8'd2;
  localparam logic [7:0] VERSION_3       = 8'd3;
  localparam logic [7:0] TYPE_SYN_REPLY  = 8'd2;
  localparam logic [15:0] STATUS_NAME_CHARS = 16'd6;
  localparam logic [15:0] STATUS_CAPTURE_LEN = 16'd3;

  // header byte offsets
  localparam logic [POS_W-1:0] POS_VER_HI   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_VER_LO   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TYPE_HI  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TYPE_LO  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PAIRS_HI = POS_W'(14);
  localparam logic [POS_W-1:0] POS_PAIRS_LO = POS_W'(15);

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_NAME_HI,
    PH_NAME_LO,
    PH_NAME_BYTES,
    PH_VAL_HI,
    PH_VAL_LO,
    PH_VAL_BYTES,
    PH_CAPTURE,
    PH_NONE,
    PH_ERR_CTRL,
    PH_ERR_VER,
    PH_ERR_TYPE
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic [23:0] status_text;
    logic [2:0]  outcome;
  } result_t;

  // expected name characters, "status"
  function automatic logic [7:0] match_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0: c = 8'h73;
      3'd1: c = 8'h74;
      3'd2: c = 8'h61;
      3'd3: c = 8'h74;
      3'd4: c = 8'h75;
      3'd5: c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: design/spdy_rse_core_top.sv
// spdy_reply_status_extract_core
// Parses a SPDY frame fed one byte per input transaction (in_frame_byte, with
// in_last_byte on the final byte) and gives at most one result transaction per
// frame: out_status_text holds the first three bytes of the value of a name starting "status" with
// out_outcome = 0, or out_status_text is 0 and out_outcome carries the error
// code (1 not control, 2 bad version, 3 not reply, 4 missing or truncated),
// given on the frame's final byte.
// Both channels use valid/ready. A byte is registered at input, parsed by the
// parser's small phase logic once the output slot is free, and the result is
// registered at output. Throughput is one byte per cycle while the output slot
// is free, set by the single parse-state update; the input register refills in
// the same cycle it drains.
// If the receiver holds out_ready low, the output register keeps its result,
// one more byte waits in the input register, and then in_ready drops.
// Synchronous reset (rst_n low) empties both registers and restarts parsing at
// the first header byte of a new frame.
module spdy_reply_status_extract_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_status_text,
  output logic [2:0]  out_outcome
);
  import spdy_rse_pkg::*;

  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  result_t    res;

  // parse a byte when one is held and the output slot can take a result
  assign advance = stg_valid && out_free;

  spdy_rse_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_frame_byte (in_frame_byte),
    .in_last_byte  (in_last_byte),
    .advance       (advance),
    .stg_valid     (stg_valid),
    .stg_byte      (stg_byte),
    .stg_last      (stg_last)
  );

  spdy_rse_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .cur_byte  (stg_byte),
    .cur_last  (stg_last),
    .res_valid (res_valid),
    .res       (res)
  );

  spdy_rse_out_stage u_out_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status_text (out_status_text),
    .out_outcome     (out_outcome)
  );

  // an error result never carries status text
  a_err_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUTCOME_FOUND |-> out_status_text == 24'd0)
    else $error("error result with nonzero status text");

  // a new result only lands in a free output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result produced while output slot is occupied");

  // backpressure at input only when a byte is held and cannot advance
  a_ready_low_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> stg_valid && !advance)
    else $error("input stalled without a held byte");

  // a held result that is taken and not replaced leaves the slot empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !res_valid |=> !out_valid)
    else $error("output valid after drain with no new result");

endmodule

// File: design/spdy_rse_in_stage.sv
module spdy_rse_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_frame_byte,
  input  logic       in_last_byte,
  input  logic       advance,
  output logic       stg_valid,
  output logic [7:0] stg_byte,
  output logic       stg_last
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  // register empties when the parser takes it, so it refills in the same cycle
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_frame_byte;
      last_r <= in_last_byte;
    end
  end

  assign stg_valid = vld_r;
  assign stg_byte  = byte_r;
  assign stg_last  = last_r;

endmodule

// File: design/spdy_rse_parser.sv
module spdy_rse_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [7:0]           cur_byte,
  input  logic                 cur_last,
  output logic                 res_valid,
  output spdy_rse_pkg::result_t res
);
  import spdy_rse_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      pairs_r, pairs_nxt;
  logic [15:0]      flen_r, flen_nxt;
  logic [15:0]      left_r, left_nxt;
  logic             match_r, match_nxt;
  logic [15:0]      shift_r, shift_nxt;
  logic             done_r, done_nxt;

  logic             live;
  logic             found;
  logic [15:0]      name_idx;
  logic [15:0]      val_len;
  logic [2:0]       err_code;

  assign live     = !done_r && (pos_r < POS_W'(MAX_FRAME_BYTES));
  assign name_idx = flen_r - left_r;
  assign val_len  = {left_r[15:8], cur_byte};

  // one byte of parsing, then end-of-frame handling
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    pairs_nxt = pairs_r;
    flen_nxt  = flen_r;
    left_nxt  = left_r;
    match_nxt = match_r;
    shift_nxt = shift_r;
    done_nxt  = done_r;
    found     = 1'b0;
    err_code  = OUTCOME_MISSING;
    res_valid = 1'b0;
    res       = '0;

    if (live) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_VER_HI) begin
            if (!cur_byte[7]) begin
              phase_nxt = PH_ERR_CTRL;
            end else begin
              flen_nxt = {9'd0, cur_byte[6:0]};
            end
          end else if (pos_r == POS_VER_LO) begin
            if (!(flen_r == 16'd0 && (cur_byte == VERSION_2 || cur_byte == VERSION_3))) begin
              phase_nxt = PH_ERR_VER;
            end
          end else if (pos_r == POS_TYPE_HI) begin
            flen_nxt = {8'd0, cur_byte};
          end else if (pos_r == POS_TYPE_LO) begin
            if (!(flen_r == 16'd0 && cur_byte == TYPE_SYN_REPLY)) begin
              phase_nxt = PH_ERR_TYPE;
            end
          end else if (pos_r == POS_PAIRS_HI) begin
            pairs_nxt = {cur_byte, 8'd0};
          end else if (pos_r == POS_PAIRS_LO) begin
            pairs_nxt = {pairs_r[15:8], cur_byte};
            flen_nxt  = '0;
            phase_nxt = ({pairs_r[15:8], cur_byte} != 16'd0) ? PH_NAME_HI : PH_NONE;
          end
        end
        PH_NAME_HI: begin
          flen_nxt  = {cur_byte, 8'd0};
          phase_nxt = PH_NAME_LO;
        end
        PH_NAME_LO: begin
          flen_nxt  = {flen_r[15:8], cur_byte};
          left_nxt  = {flen_r[15:8], cur_byte};
          match_nxt = ({flen_r[15:8], cur_byte} >= STATUS_NAME_CHARS);
          phase_nxt = ({flen_r[15:8], cur_byte} != 16'd0) ? PH_NAME_BYTES : PH_VAL_HI;
        end
        PH_NAME_BYTES: begin
          if (name_idx < STATUS_NAME_CHARS && cur_byte != match_char(name_idx[2:0])) begin
            match_nxt = 1'b0;
          end
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            phase_nxt = PH_VAL_HI;
          end
        end
        PH_VAL_HI: begin
          left_nxt  = {cur_byte, 8'd0};
          phase_nxt = PH_VAL_LO;
        end
        PH_VAL_LO: begin
          if (match_r) begin
            left_nxt  = STATUS_CAPTURE_LEN;
            shift_nxt = '0;
            phase_nxt = PH_CAPTURE;
          end else if (val_len != 16'd0) begin
            left_nxt  = val_len;
            phase_nxt = PH_VAL_BYTES;
          end else begin
            left_nxt  = val_len;
            pairs_nxt = pairs_r - 16'd1;
            phase_nxt = (pairs_r != 16'd1) ? PH_NAME_HI : PH_NONE;
          end
        end
        PH_VAL_BYTES: begin
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            pairs_nxt = pairs_r - 16'd1;
            phase_nxt = (pairs_r != 16'd1) ? PH_NAME_HI : PH_NONE;
          end
        end
        PH_CAPTURE: begin
          shift_nxt = {shift_r[7:0], cur_byte};
          left_nxt  = left_r - 16'd1;
          if (left_r == 16'd1) begin
            found     = 1'b1;
            done_nxt  = 1'b1;
            res_valid = 1'b1;
            res.status_text = {shift_r, cur_byte};
            res.outcome     = OUTCOME_FOUND;
          end
        end
        default: begin
        end
      endcase
    end

    // byte counter saturates at the frame bound
    if (pos_r < POS_W'(MAX_FRAME_BYTES)) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    // error code from the phase this byte leaves behind
    priority if (phase_nxt == PH_ERR_CTRL) begin
      err_code = OUTCOME_NOT_CONTROL;
    end else if (phase_nxt == PH_ERR_VER) begin
      err_code = OUTCOME_BAD_VERSION;
    end else if (phase_nxt == PH_ERR_TYPE) begin
      err_code = OUTCOME_NOT_REPLY;
    end else begin
      err_code = OUTCOME_MISSING;
    end

    // frame end: report failure if nothing was given, then restart
    if (cur_last) begin
      if (!done_r && !found) begin
        res_valid = 1'b1;
        res.status_text = '0;
        res.outcome     = err_code;
      end
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      pairs_nxt = '0;
      flen_nxt  = '0;
      left_nxt  = '0;
      match_nxt = 1'b0;
      shift_nxt = '0;
      done_nxt  = 1'b0;
    end

    if (!advance) begin
      res_valid = 1'b0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      pairs_r <= '0;
      flen_r  <= '0;
      left_r  <= '0;
      match_r <= 1'b0;
      shift_r <= '0;
      done_r  <= 1'b0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      pairs_r <= pairs_nxt;
      flen_r  <= flen_nxt;
      left_r  <= left_nxt;
      match_r <= match_nxt;
      shift_r <= shift_nxt;
      done_r  <= done_nxt;
    end
  end

  // a finished frame stays in the capture phase until its last byte
  a_done_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> phase_r == PH_CAPTURE)
    else $error("frame marked finished outside capture");

endmodule

// File: design/spdy_rse_out_stage.sv
module spdy_rse_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  spdy_rse_pkg::result_t res,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [23:0]           out_status_text,
  output logic [2:0]            out_outcome
);
  import spdy_rse_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  // slot is free when empty or being drained this cycle
  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (res_valid) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = vld_r;
  assign out_status_text = res_r.status_text;
  assign out_outcome     = res_r.outcome;

endmodule

// File: bench/tb_spdy_reply_status_extract_core.sv
`timescale 1ns / 100ps

module tb_spdy_reply_status_extract_core;
  import spdy_rse_pkg::*;

  localparam int STALL_LIMIT = 2000;   // several times the longest receiver hold-off
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT_BYTE = 300;
  localparam int RANDOM_BYTES = 1525;
  localparam logic [47:0] STATUS_WORD = "status";

  typedef enum int {NAME_EXACT, NAME_LONGER, NAME_PREFIX, NAME_ALTERED, NAME_RANDOM} name_kind_t;
  typedef enum int {BREAK_CONTROL, BREAK_VERSION, BREAK_TYPE, BREAK_NOISE} broken_kind_t;

  // one byte waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain_first;
  } frame_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_frame_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_status_text;
  logic [2:0]  out_outcome;

  frame_item_t pending_bytes[$];
  logic [7:0]  frame_buf[$];
  result_t     expected_status[$];

  bit in_taken = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int bytes_taken = 0;
  int stall_cycles = 0;
  int mismatches = 0;
  int frames_sent = 0;
  int outcome_seen [0:4] = '{default: 0};

  wire no_idle_stretch = (bytes_taken >= 700) && (bytes_taken < 1000);

  // parser state of the prediction
  logic [POS_W-1:0] frame_pos;
  phase_t           parse_ph;
  logic [15:0]      pairs_todo;
  logic [15:0]      field_len;
  logic [15:0]      field_left;
  logic             name_ok;
  logic [23:0]      status_acc;
  logic             frame_done;

  spdy_reply_status_extract_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_frame_byte(in_frame_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status_text(out_status_text),
    .out_outcome(out_outcome)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_frame_state();
    frame_pos = '0;
    parse_ph = PH_HEADER;
    pairs_todo = '0;
    field_len = '0;
    field_left = '0;
    name_ok = 1'b0;
    status_acc = '0;
    frame_done = 1'b0;
  endtask

  // expected result of one accepted byte
  task automatic predict_status_byte(input logic [7:0] b, input logic last);
    logic        hit;
    logic [15:0] idx;
    logic [2:0]  code;
    hit = 1'b0;
    if (!frame_done && frame_pos < MAX_FRAME_BYTES) begin
      case (parse_ph)
        PH_HEADER: begin
          case (frame_pos)
            POS_VER_HI: begin
              if (!b[7]) parse_ph = PH_ERR_CTRL;
              else field_len = {9'd0, b[6:0]};
            end
            POS_VER_LO: begin
              if ({field_len[7:0], b} != {8'h00, VERSION_2} &&
                  {field_len[7:0], b} != {8'h00, VERSION_3}) parse_ph = PH_ERR_VER;
            end
            POS_TYPE_HI: field_len = {8'h00, b};
            POS_TYPE_LO: begin
              if ({field_len[7:0], b} != {8'h00, TYPE_SYN_REPLY}) parse_ph = PH_ERR_TYPE;
            end
            POS_PAIRS_HI: pairs_todo = {b, 8'h00};
            POS_PAIRS_LO: begin
              pairs_todo = {pairs_todo[15:8], b};
              field_len = '0;
              parse_ph = (pairs_todo != 0) ? PH_NAME_HI : PH_NONE;
            end
            default: ;
          endcase
        end
        PH_NAME_HI: begin
          field_len = {b, 8'h00};
          parse_ph = PH_NAME_LO;
        end
        PH_NAME_LO: begin
          field_len = {field_len[15:8], b};
          field_left = field_len;
          name_ok = (field_len >= STATUS_NAME_CHARS);
          parse_ph = (field_len != 0) ? PH_NAME_BYTES : PH_VAL_HI;
        end
        PH_NAME_BYTES: begin
          idx = field_len - field_left;
          if (idx < 6) begin
            if (b != STATUS_WORD[47 - 8*idx -: 8]) name_ok = 1'b0;
          end
          field_left = field_left - 1'b1;
          if (field_left == 0) parse_ph = PH_VAL_HI;
        end
        PH_VAL_HI: begin
          field_left = {b, 8'h00};
          parse_ph = PH_VAL_LO;
        end
        PH_VAL_LO: begin
          field_left = {field_left[15:8], b};
          if (name_ok) begin
            field_left = STATUS_CAPTURE_LEN;
            status_acc = '0;
            parse_ph = PH_CAPTURE;
          end else if (field_left != 0) begin
            parse_ph = PH_VAL_BYTES;
          end else begin
            pairs_todo = pairs_todo - 1'b1;
            parse_ph = (pairs_todo != 0) ? PH_NAME_HI : PH_NONE;
          end
        end
        PH_VAL_BYTES: begin
          field_left = field_left - 1'b1;
          if (field_left == 0) begin
            pairs_todo = pairs_todo - 1'b1;
            parse_ph = (pairs_todo != 0) ? PH_NAME_HI : PH_NONE;
          end
        end
        PH_CAPTURE: begin
          status_acc = {status_acc[15:0], b};
          field_left = field_left - 1'b1;
          if (field_left == 0) begin
            expected_status.push_back('{status_text: status_acc, outcome: OUTCOME_FOUND});
            frame_done = 1'b1;
            hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (frame_pos < MAX_FRAME_BYTES) frame_pos = frame_pos + 1'b1;

    // frame end: error code unless the status was already given
    if (last) begin
      if (!frame_done && !hit) begin
        case (parse_ph)
          PH_ERR_CTRL: code = OUTCOME_NOT_CONTROL;
          PH_ERR_VER:  code = OUTCOME_BAD_VERSION;
          PH_ERR_TYPE: code = OUTCOME_NOT_REPLY;
          default:     code = OUTCOME_MISSING;
        endcase
        expected_status.push_back('{status_text: 24'h000000, outcome: code});
      end
      clear_frame_state();
    end
  endtask

  // frame building
  task automatic add_len16(input logic [15:0] v);
    frame_buf.push_back(v[15:8]);
    frame_buf.push_back(v[7:0]);
  endtask

  task automatic add_reply_header();
    frame_buf.push_back(8'h80);
    frame_buf.push_back($urandom_range(0, 1) ? VERSION_3 : VERSION_2);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(TYPE_SYN_REPLY);
    repeat (10) frame_buf.push_back(8'($urandom));
  endtask

  task automatic add_name(input name_kind_t kind);
    int n;
    int i;
    int flip;
    case (kind)
      NAME_EXACT:   n = 6;
      NAME_LONGER:  n = $urandom_range(7, 10);
      NAME_PREFIX:  n = $urandom_range(1, 5);
      NAME_ALTERED: n = $urandom_range(6, 8);
      default:      n = $urandom_range(0, 8);
    endcase
    add_len16(16'(n));
    flip = $urandom_range(0, 5);
    for (i = 0; i < n; i++) begin
      if (kind == NAME_RANDOM || i >= 6)
        frame_buf.push_back(8'($urandom));
      else if (kind == NAME_ALTERED && i == flip)
        frame_buf.push_back(STATUS_WORD[47 - 8*i -: 8] ^ 8'($urandom_range(1, 255)));
      else
        frame_buf.push_back(STATUS_WORD[47 - 8*i -: 8]);
    end
  endtask

  // hand a built frame to the sender, last flag on its final byte
  task automatic send_frame(input bit drain);
    frame_item_t item;
    foreach (frame_buf[i]) begin
      item.data = frame_buf[i];
      item.last = (i == frame_buf.size() - 1);
      item.drain_first = drain && (i == 0);
      pending_bytes.push_back(item);
    end
    frames_sent++;
    frame_buf.delete();
  endtask

  task automatic cut_frame();
    int cut;
    cut = $urandom_range(1, frame_buf.size());
    while (frame_buf.size() > cut) void'(frame_buf.pop_back());
  endtask

  // mostly well-formed reply with random pairs; sometimes a wrong pair count or overlong name, or cut short
  task automatic build_reply_frame();
    int npairs;
    int status_at;
    int k;
    int vlen;
    add_reply_header();
    npairs = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 4);
    status_at = $urandom_range(0, npairs);
    case ($urandom_range(9))
      8:       add_len16(16'($urandom));
      9:       add_len16(16'(npairs + 1));
      default: add_len16(16'(npairs));
    endcase
    for (k = 0; k < npairs; k++) begin
      if (k != status_at && $urandom_range(19) == 0) begin
        // name length far beyond the frame
        add_len16(16'($urandom_range(256, 65535)));
        repeat ($urandom_range(0, 6)) frame_buf.push_back(8'($urandom));
        break;
      end
      if (k == status_at) begin
        add_name(name_kind_t'($urandom_range(NAME_EXACT, NAME_LONGER)));
        vlen = $urandom_range(0, 5);
      end else begin
        add_name(name_kind_t'($urandom_range(NAME_PREFIX, NAME_RANDOM)));
        vlen = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      end
      add_len16(16'(vlen));
      repeat (vlen) frame_buf.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
    if ($urandom_range(99) < 15) cut_frame();
  endtask

  // header errors and plain noise
  task automatic build_broken_frame();
    broken_kind_t kind;
    logic [15:0]  word;
    kind = broken_kind_t'($urandom_range(BREAK_CONTROL, BREAK_NOISE));
    add_reply_header();
    repeat ($urandom_range(0, 8)) frame_buf.push_back(8'($urandom));
    case (kind)
      BREAK_CONTROL: frame_buf[0] = 8'($urandom_range(0, 127));
      BREAK_VERSION: begin
        word = $urandom_range(1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        word[15] = 1'b1;
        if (word[14:0] == {7'h00, VERSION_2} || word[14:0] == {7'h00, VERSION_3})
          word[2] = 1'b1;
        frame_buf[0] = word[15:8];
        frame_buf[1] = word[7:0];
      end
      BREAK_TYPE: begin
        word = 16'($urandom);
        if (word == {8'h00, TYPE_SYN_REPLY}) word[8] = 1'b1;
        frame_buf[2] = word[15:8];
        frame_buf[3] = word[7:0];
      end
      default: foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    endcase
    cut_frame();
  endtask

  // sender: one byte transaction at a time, changed on the falling edge
  always @(negedge clk) begin : sender
    frame_item_t item;
    if (rst_n !== 1'b1) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 &&
          !(pending_bytes[0].drain_first && expected_status.size() != 0) &&
          (no_idle_stretch || hold_left != 0 || $urandom_range(99) >= 34)) begin
        item = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_frame_byte <= item.data;
        in_last_byte <= item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin : receiver
    if (rst_n !== 1'b1) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT_BYTE) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle_stretch || ($urandom_range(99) >= 34);
    end
  end

  // monitor: predict on input transactions, compare on result transactions
  always @(posedge clk) begin : monitor
    result_t want;
    logic    out_taken;
    if (rst_n === 1'b1) begin
      in_taken = in_valid && in_ready;
      out_taken = out_valid && out_ready;
      if (out_taken) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("unexpected result status_text=%06h outcome=%0d",
                                    out_status_text, out_outcome));
        end else begin
          want = expected_status.pop_front();
          if (out_status_text !== want.status_text)
            report_mismatch($sformatf("status_text %06h, expected %06h",
                                      out_status_text, want.status_text));
          if (out_outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, expected %0d", out_outcome, want.outcome));
        end
        if (out_outcome <= OUTCOME_MISSING) outcome_seen[out_outcome]++;
      end
      if (in_taken) begin
        predict_status_byte(in_frame_byte, in_last_byte);
        bytes_taken++;
      end
      if (in_taken || out_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("spdy_reply_status_extract_core test failed");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int random_bytes;
    int size_then;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_frame_byte = 8'h00;
    in_last_byte = 1'b0;
    out_ready = 1'b0;
    clear_frame_state();

    // directed: each header error, short frames, zero pairs
    frame_buf.push_back(8'h00);
    send_frame(1'b0);
    frame_buf.push_back(8'h7F);
    send_frame(1'b0);
    frame_buf.push_back(8'hFF);
    send_frame(1'b0);
    frame_buf.push_back(8'h80);
    frame_buf.push_back(8'h04);
    send_frame(1'b0);
    frame_buf.push_back(8'h80);
    frame_buf.push_back(VERSION_3);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h03);
    send_frame(1'b0);
    add_reply_header();
    add_len16(16'h0000);
    send_frame(1'b0);

    // random frames, mostly well-formed replies
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      size_then = pending_bytes.size();
      if ($urandom_range(99) < 70) build_reply_frame();
      else build_broken_frame();
      send_frame((frames_sent % 17) == 5);
      random_bytes += pending_bytes.size() - size_then;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_status.size()));

    $display("covered %0d frames in %0d byte transactions, with header errors and cut frames",
             frames_sent, bytes_taken);
    $display("results: found %0d, not control %0d, bad version %0d, not reply %0d, missing %0d",
             outcome_seen[OUTCOME_FOUND], outcome_seen[OUTCOME_NOT_CONTROL],
             outcome_seen[OUTCOME_BAD_VERSION], outcome_seen[OUTCOME_NOT_REPLY],
             outcome_seen[OUTCOME_MISSING]);
    if (mismatches == 0) begin
      $display("spdy_reply_status_extract_core test passed");
    end else begin
      $display("spdy_reply_status_extract_core test failed");
    end
    $finish;
  end

endmodule

// File: spdy_reply_status_extract_core.f
design/spdy_rse_pkg.sv
design/spdy_rse_in_stage.sv
design/spdy_rse_parser.sv
design/spdy_rse_out_stage.sv
design/spdy_rse_core_top.sv
bench/tb_spdy_reply_status_extract_core.sv
